// File: hw/rtl/hsv2rgb_pkg.sv
// Shared types and constants for the integer HSV to RGB converter.
// No dependencies.
package hsv2rgb_pkg;

  localparam int unsigned HueW  = 8;
  localparam int unsigned SatW  = 8;
  localparam int unsigned ChanW = 16;
  localparam int unsigned FracW = 8;
  localparam int unsigned RgnW  = 3;
  localparam int unsigned ProdW = ChanW + SatW;   // level times 8-bit factor

  localparam logic [SatW-1:0] FULL8 = 8'd255;

  // Hue sectors after hue*6 (red-yellow, yellow-green, ...); magenta-red is the default arm
  localparam logic [RgnW-1:0] SEG_RY = 3'd0;
  localparam logic [RgnW-1:0] SEG_YG = 3'd1;
  localparam logic [RgnW-1:0] SEG_GC = 3'd2;
  localparam logic [RgnW-1:0] SEG_CB = 3'd3;
  localparam logic [RgnW-1:0] SEG_BM = 3'd4;
  localparam logic [RgnW-1:0] SEG_MR = 3'd5;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_out_t;

endpackage

// File: hw/rtl/hsv_to_rgb_integer.sv
// Integer HSV to RGB converter, three-stage pipeline with valid/ready on both sides.
// Depends on hsv2rgb_pkg.
//
// Stages: 3 register stages; out_valid is driven by the stage-3 valid bit.
// Throughput: one item per cycle while out_ready is high; the stage-2 8x16 multipliers set the critical path.
// Reset: rst_n synchronous, active low; clears all stage valid bits, payload is not reset.
module hsv_to_rgb_integer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  hsv2rgb_pkg::hsv_in_t    in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output hsv2rgb_pkg::rgb_out_t   out_item
);

  // ---------------------------------------------------------------------------
  // Stall chain: a stage takes new data when it is empty or its successor moves.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // ---------------------------------------------------------------------------
  // Stage 1: hue*6 (shift-add) into sector and fraction, then the two
  // saturation-by-fraction products that shape the crossfades.
  // ---------------------------------------------------------------------------
  logic [hsv2rgb_pkg::RgnW+hsv2rgb_pkg::FracW-1:0] scaled;
  logic [hsv2rgb_pkg::FracW-1:0]                   frac;
  logic [2*hsv2rgb_pkg::SatW-1:0]                  sf_nxt, sr_nxt;

  assign scaled = {1'b0, in_item.hue, 2'b00} + {2'b00, in_item.hue, 1'b0};
  assign frac   = scaled[hsv2rgb_pkg::FracW-1:0];
  assign sf_nxt = in_item.saturation * frac;
  assign sr_nxt = in_item.saturation * (hsv2rgb_pkg::FULL8 - frac);

  logic [hsv2rgb_pkg::RgnW-1:0]   rgn1_r;
  logic [2*hsv2rgb_pkg::SatW-1:0] sf1_r, sr1_r;
  logic [hsv2rgb_pkg::SatW-1:0]   sat1_r;
  logic [hsv2rgb_pkg::ChanW-1:0]  lvl1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (in_valid && rdy1) begin
      rgn1_r <= scaled[hsv2rgb_pkg::RgnW+hsv2rgb_pkg::FracW-1:hsv2rgb_pkg::FracW];
      sf1_r  <= sf_nxt;
      sr1_r  <= sr_nxt;
      sat1_r <= in_item.saturation;
      lvl1_r <= in_item.brightness;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: three level-by-factor products (floor, falling, rising).
  // Each factor is 255 minus an 8-bit term, so it never underflows.
  // ---------------------------------------------------------------------------
  logic [hsv2rgb_pkg::SatW-1:0]  fac_fl, fac_fa, fac_ri;
  logic [hsv2rgb_pkg::ProdW-1:0] pfl_nxt, pfa_nxt, pri_nxt;

  assign fac_fl  = hsv2rgb_pkg::FULL8 - sat1_r;
  assign fac_fa  = hsv2rgb_pkg::FULL8 - sf1_r[2*hsv2rgb_pkg::SatW-1:hsv2rgb_pkg::SatW];
  assign fac_ri  = hsv2rgb_pkg::FULL8 - sr1_r[2*hsv2rgb_pkg::SatW-1:hsv2rgb_pkg::SatW];
  assign pfl_nxt = lvl1_r * fac_fl;
  assign pfa_nxt = lvl1_r * fac_fa;
  assign pri_nxt = lvl1_r * fac_ri;

  logic [hsv2rgb_pkg::RgnW-1:0]  rgn2_r;
  logic                          grey2_r;
  logic [hsv2rgb_pkg::ChanW-1:0] lvl2_r;
  logic [hsv2rgb_pkg::ProdW-1:0] pfl2_r, pfa2_r, pri2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (v1_r && rdy2) begin
      rgn2_r  <= rgn1_r;
      grey2_r <= (sat1_r == '0);
      lvl2_r  <= lvl1_r;
      pfl2_r  <= pfl_nxt;
      pfa2_r  <= pfa_nxt;
      pri2_r  <= pri_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: drop the low byte and route shapes to channels by sector.
  // Grey items bypass the shapes entirely.
  // ---------------------------------------------------------------------------
  logic [hsv2rgb_pkg::ChanW-1:0] flr, fal, ris;
  hsv2rgb_pkg::rgb_out_t         rgb_nxt;
  hsv2rgb_pkg::rgb_out_t         rgb_r;

  assign flr = pfl2_r[hsv2rgb_pkg::ProdW-1:hsv2rgb_pkg::SatW];
  assign fal = pfa2_r[hsv2rgb_pkg::ProdW-1:hsv2rgb_pkg::SatW];
  assign ris = pri2_r[hsv2rgb_pkg::ProdW-1:hsv2rgb_pkg::SatW];

  always_comb begin
    rgb_nxt.red   = flr;
    rgb_nxt.green = flr;
    rgb_nxt.blue  = flr;
    if (grey2_r) begin
      rgb_nxt.red   = lvl2_r;
      rgb_nxt.green = lvl2_r;
      rgb_nxt.blue  = lvl2_r;
    end else begin
      case (rgn2_r)
        hsv2rgb_pkg::SEG_RY: begin
          rgb_nxt.red   = lvl2_r;
          rgb_nxt.green = ris;
        end
        hsv2rgb_pkg::SEG_YG: begin
          rgb_nxt.red   = fal;
          rgb_nxt.green = lvl2_r;
        end
        hsv2rgb_pkg::SEG_GC: begin
          rgb_nxt.green = lvl2_r;
          rgb_nxt.blue  = ris;
        end
        hsv2rgb_pkg::SEG_CB: begin
          rgb_nxt.green = fal;
          rgb_nxt.blue  = lvl2_r;
        end
        hsv2rgb_pkg::SEG_BM: begin
          rgb_nxt.red  = ris;
          rgb_nxt.blue = lvl2_r;
        end
        default: begin      // magenta-red sector and anything above it
          rgb_nxt.red  = lvl2_r;
          rgb_nxt.blue = fal;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
    if (v2_r && rdy3) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_item  = rgb_r;

`ifndef ASSERT_OFF
  // hue*6 of an 8-bit hue never reaches past the magenta-red sector
  a_rgn_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (rgn1_r <= hsv2rgb_pkg::SEG_MR))
    else $error("sector out of range");

  // a blocked stage 2 keeps its products
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(pfl2_r) && $stable(pfa2_r) && $stable(pri2_r)))
    else $error("stage 2 lost data under stall");

  // grey item leaves with equal channels
  a_grey_eq: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && rdy3 && grey2_r) |=>
      (rgb_r.red == rgb_r.green && rgb_r.green == rgb_r.blue))
    else $error("grey item with unequal channels");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
